// ===== rtl/core/mtm_pkg.sv =====
// shared types and opcode codes for the multi timer manager
package mtm_pkg;

    localparam int TIME_W  = 32;
    localparam int ID_W    = 4;
    localparam int MASK_W  = 16;
    localparam int TB_W    = 16;

    localparam logic [1:0] OP_SETUP = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // one timer's record as it travels around the ring
    typedef struct packed {
        logic              active;
        logic              oneshot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] start;
    } t_timer_rec;

    // direct update of one addressed cell while the ring is at rest
    typedef struct packed {
        logic              setup;
        logic              start;
        logic              stop;
        logic [ID_W-1:0]   id;
        logic              oneshot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] stamp;
    } t_cell_cmd;

endpackage

// ===== rtl/core/multi_timer_manager.sv =====
// top level of the multi timer manager: command decode, timer ring and result register
//
// Input channel (i_valid / o_stall) carries one command item: set up, start, stop or tick.
// Output channel (o_valid / i_stall) returns one item per command: fired mask and clock.
// Set-up, start and stop update the addressed timer cell directly; their result is
// registered and valid in the cycle after acceptance, so they can follow each other
// every cycle while the receiver keeps up.
// A tick adds the timebase to the clock, then rotates the ring of NUM_TIMERS cells once
// through a single shared expiry comparator, one timer per cycle. Its result is
// registered when the scan reaches the last timer, and no new item is taken
// before the block is back at rest.
// The result register lets a new item in during the same cycle its content is taken.
// While the receiver stalls, the result holds and o_stall stays high.
// Reset (synchronous, active low) clears the clock and every timer record: all timers
// idle, periods and start times zero. No clearing pass is needed.
// Timer ids at or above NUM_TIMERS are ignored; only timers 0 to 15 appear in the mask.
module multi_timer_manager #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [mtm_pkg::ID_W-1:0]      i_timer_id,
    input  logic                          i_oneshot,
    input  logic [mtm_pkg::TIME_W-1:0]    i_period,
    input  logic [mtm_pkg::TB_W-1:0]      i_timebase,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mtm_pkg::MASK_W-1:0]    o_fired_mask,
    output logic [mtm_pkg::TIME_W-1:0]    o_now_time
);

    localparam int CNT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IDX_W = 7;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                      r_state;
    logic [CNT_W-1:0]            r_cnt;
    logic [mtm_pkg::TIME_W-1:0]  r_clock;
    logic [mtm_pkg::MASK_W-1:0]  r_mask;
    logic                        r_out_valid;
    logic [mtm_pkg::MASK_W-1:0]  r_out_mask;
    logic [mtm_pkg::TIME_W-1:0]  r_out_time;

    logic                        w_accept;
    logic                        w_shift;
    logic                        w_last;
    logic                        w_fire;
    logic [IDX_W-1:0]            w_idx;
    logic [mtm_pkg::MASK_W-1:0]  w_bit;
    mtm_pkg::t_cell_cmd          w_cmd;
    mtm_pkg::t_timer_rec         w_rec [NUM_TIMERS];
    mtm_pkg::t_timer_rec         w_checked;

    assign o_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_stall));
    assign w_accept = i_valid && !o_stall;
    assign w_shift  = (r_state == S_SCAN);
    assign w_last   = (r_cnt == CNT_W'(NUM_TIMERS - 1));

    always_comb begin
        w_cmd            = '0;
        w_cmd.setup      = w_accept && (i_opcode == mtm_pkg::OP_SETUP);
        w_cmd.start      = w_accept && (i_opcode == mtm_pkg::OP_START);
        w_cmd.stop       = w_accept && (i_opcode == mtm_pkg::OP_STOP);
        w_cmd.id         = i_timer_id;
        w_cmd.oneshot    = i_oneshot;
        w_cmd.period     = i_period;
        w_cmd.stamp      = r_clock;
    end

    // the record at the ring's end after r_cnt shifts belongs to timer NUM_TIMERS-1-r_cnt
    assign w_idx = IDX_W'(NUM_TIMERS - 1) - IDX_W'(r_cnt);
    assign w_bit = (w_fire && (w_idx < IDX_W'(mtm_pkg::MASK_W)))
                 ? (mtm_pkg::MASK_W'(1) << w_idx[3:0]) : '0;

    mtm_check u_check (
        .i_rec  (w_rec[NUM_TIMERS-1]),
        .i_now  (r_clock),
        .o_rec  (w_checked),
        .o_fire (w_fire)
    );

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        mtm_pkg::t_timer_rec w_prev;
        if (g == 0) begin : g_head
            assign w_prev = w_checked;
        end else begin : g_body
            assign w_prev = w_rec[g-1];
        end
        mtm_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_prev  (w_prev),
            .i_cmd   (w_cmd),
            .o_rec   (w_rec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_clock     <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
            r_out_mask  <= '0;
            r_out_time  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_opcode != mtm_pkg::OP_TICK)) begin
                        r_out_valid <= 1'b1;
                        r_out_mask  <= '0;
                        r_out_time  <= r_clock;
                    end else begin
                        if (r_out_valid && !i_stall) begin
                            r_out_valid <= 1'b0;
                        end
                        if (w_accept) begin
                            r_clock <= r_clock + mtm_pkg::TIME_W'(i_timebase);
                            r_cnt   <= '0;
                            r_mask  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                // the result register is empty for the whole scan
                S_SCAN: begin
                    if (w_last) begin
                        r_out_valid <= 1'b1;
                        r_out_mask  <= r_mask | w_bit;
                        r_out_time  <= r_clock;
                        r_cnt       <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_mask <= r_mask | w_bit;
                        r_cnt  <= r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_fired_mask = r_out_mask;
    assign o_now_time   = r_out_time;

    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> o_stall)
        else $error("item accepted during ring scan");

    a_idle_counter_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("scan counter not cleared at rest");

    a_tick_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == mtm_pkg::OP_TICK)) |=> (r_state == S_SCAN))
        else $error("tick did not start a scan");

    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode != mtm_pkg::OP_TICK))
            |=> (o_valid && (o_fired_mask == '0) && (o_now_time == r_clock)))
        else $error("command result missing or wrong");

endmodule

// ===== rtl/core/mtm_cell.sv =====
// one ring cell holding the record of one timer slot
module mtm_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  mtm_pkg::t_timer_rec i_prev,
    input  mtm_pkg::t_cell_cmd  i_cmd,
    output mtm_pkg::t_timer_rec o_rec
);

    localparam bit ADDRESSABLE = (IDX < (1 << mtm_pkg::ID_W));
    localparam logic [mtm_pkg::ID_W-1:0] MY_ID = mtm_pkg::ID_W'(IDX);

    mtm_pkg::t_timer_rec r_rec;
    mtm_pkg::t_timer_rec n_rec;
    logic                w_hit;

    assign w_hit = ADDRESSABLE && (i_cmd.id == MY_ID);

    always_comb begin
        n_rec = r_rec;
        if (i_shift) begin
            n_rec = i_prev;
        end else if (w_hit) begin
            if (i_cmd.setup) begin
                n_rec.oneshot = i_cmd.oneshot;
                n_rec.period  = i_cmd.period;
            end
            if (i_cmd.start) begin
                n_rec.start  = i_cmd.stamp;
                n_rec.active = 1'b1;
            end
            if (i_cmd.stop) begin
                n_rec.active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= '0;
        end else begin
            r_rec <= n_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

// ===== rtl/core/mtm_check.sv =====
// shared expiry check applied to the record leaving the end of the ring
module mtm_check (
    input  mtm_pkg::t_timer_rec          i_rec,
    input  logic [mtm_pkg::TIME_W-1:0]   i_now,
    output mtm_pkg::t_timer_rec          o_rec,
    output logic                         o_fire
);

    logic [mtm_pkg::TIME_W-1:0] w_elapsed;

    // wrapping difference handles clock rollover
    assign w_elapsed = i_now - i_rec.start;
    assign o_fire    = i_rec.active && (w_elapsed >= i_rec.period);

    always_comb begin
        o_rec = i_rec;
        if (o_fire) begin
            o_rec.start = i_now;
            if (i_rec.oneshot) begin
                o_rec.active = 1'b0;
            end
        end
    end

endmodule
